// ===== hw/rtl/huffman_tree_walk_decoder_core_defines.svh =====
// Assertion macros used by the checker.
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HTWD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/htwd_pkg.sv =====
package htwd_pkg;

    localparam int IDX_W = 9;
    localparam int SYM_W = 8;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] MAX_BITS = 4'd8;

    // Command codes
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_DECODE  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // One tree node as stored in the node memory
    typedef struct packed {
        logic [IDX_W-1:0] zero_child;
        logic [IDX_W-1:0] one_child;
        logic             is_leaf;
        logic [SYM_W-1:0] symbol;
    } node_t;

    // Child taken for one compressed bit
    function automatic logic [IDX_W-1:0] child_of(input node_t n, input logic b);
        return b ? n.one_child : n.zero_child;
    endfunction

endpackage

// ===== hw/rtl/htwd_node_mem.sv =====
module htwd_node_mem #(
    parameter int DEPTH = 512
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     addr,
    input  htwd_pkg::node_t              wdata,
    output htwd_pkg::node_t              rdata
);
    import htwd_pkg::*;

    node_t mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== hw/rtl/huffman_tree_walk_decoder_core.sv =====
// Channel | Handshake          | Payload
// --------+--------------------+------------------------------------------------
// in      | in_valid/in_ready  | cmd node_index zero_child one_child is_leaf
//         |                    | leaf_symbol data_byte valid_bits
// out     | out_valid/out_ready| symbol last
//
// Node write and restart complete in state IDLE. A decode walks its bits in state EVAL,
// one node memory read per bit, chained, then passes FLUSH when it yields a symbol.
// Reset puts the walk at the root; node memory contents are undefined until written.
// A full output register stalls the walk at a leaf once a symbol is already pending,
// and stalls the final symbol of the byte; the input stays closed meanwhile.
// A new item is taken while the last symbol still waits in the output register.
module huffman_tree_walk_decoder_core #(
    parameter int NODE_COUNT = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [8:0] node_index,
    input  logic [8:0] zero_child,
    input  logic [8:0] one_child,
    input  logic       is_leaf,
    input  logic [7:0] leaf_symbol,
    input  logic [7:0] data_byte,
    input  logic [3:0] valid_bits,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] symbol,
    output logic       last
);
    import htwd_pkg::*;

    localparam int ADDR_W = $clog2(NODE_COUNT);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < NODE_COUNT;
    endfunction

    // Control state
    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] walk_idx_reg, walk_idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Payload
    node_t            cur_node_reg, cur_node_next;
    node_t            root_node_reg, root_node_next;
    logic [7:0]       data_reg, data_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_oor_reg, rd_oor_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic [SYM_W-1:0] out_sym_reg, out_sym_next;
    logic             out_last_reg, out_last_next;

    // Memory port
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_idx;
    node_t            mem_wdata;
    node_t            mem_rdata;

    logic             in_xfer;
    logic             can_push;
    logic [CNT_W-1:0] nbits;
    node_t            child;
    node_t            new_cur;
    logic [IDX_W-1:0] next_idx;

    htwd_node_mem #(
        .DEPTH (NODE_COUNT)
    ) u_htwd_node_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (ADDR_W'(mem_idx)),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign can_push  = !out_valid_reg || out_ready;
    assign nbits     = (valid_bits > MAX_BITS) ? MAX_BITS : valid_bits;
    assign mem_wdata = '{zero_child: zero_child, one_child: one_child,
                         is_leaf: is_leaf, symbol: leaf_symbol};

    // Node reached by the bit in flight; out of range reads as all zero
    assign child    = rd_oor_reg ? '0 : mem_rdata;
    assign new_cur  = child.is_leaf ? root_node_reg : child;
    assign next_idx = child_of(new_cur, data_reg[0]);

    // Walk sequencer
    always_comb
    begin
        state_next      = state_reg;
        walk_idx_next   = walk_idx_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cnt_next        = cnt_reg;
        cur_node_next   = cur_node_reg;
        root_node_next  = root_node_reg;
        data_next       = data_reg;
        rd_idx_next     = rd_idx_reg;
        rd_oor_next     = rd_oor_reg;
        pend_sym_next   = pend_sym_reg;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_idx         = node_index;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (cmd)
                        CMD_WRITE:
                        begin
                            if (in_range(node_index))
                            begin
                                mem_we = 1'b1;
                                if (node_index == '0)
                                begin
                                    root_node_next = mem_wdata;
                                end
                                // keep the held copy of the current node coherent
                                if (node_index == walk_idx_reg)
                                begin
                                    cur_node_next = mem_wdata;
                                end
                            end
                        end
                        CMD_DECODE:
                        begin
                            if (nbits != '0)
                            begin
                                mem_re      = 1'b1;
                                mem_idx     = child_of(cur_node_reg, data_byte[0]);
                                rd_idx_next = mem_idx;
                                rd_oor_next = !in_range(mem_idx);
                                data_next   = data_byte >> 1;
                                cnt_next    = nbits;
                                state_next  = ST_EVAL;
                            end
                        end
                        CMD_RESTART:
                        begin
                            walk_idx_next = '0;
                            cur_node_next = root_node_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_EVAL:
            begin
                // hold at a leaf while an older symbol cannot leave
                if (!(child.is_leaf && pend_valid_reg && !can_push))
                begin
                    if (child.is_leaf)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_sym_next   = pend_sym_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = child.symbol;
                        walk_idx_next   = '0;
                    end
                    else
                    begin
                        walk_idx_next = rd_idx_reg;
                    end
                    cur_node_next = new_cur;

                    if (cnt_reg > 4'd1)
                    begin
                        mem_re      = 1'b1;
                        mem_idx     = next_idx;
                        rd_idx_next = next_idx;
                        rd_oor_next = !in_range(next_idx);
                        data_next   = data_reg >> 1;
                        cnt_next    = cnt_reg - 4'd1;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = (child.is_leaf || pend_valid_reg) ? ST_FLUSH : ST_IDLE;
                    end
                end
            end

            ST_FLUSH:
            begin
                // final symbol of the byte
                if (can_push)
                begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = pend_sym_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            walk_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            walk_idx_reg   <= walk_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_node_reg  <= cur_node_next;
        root_node_reg <= root_node_next;
        data_reg      <= data_next;
        rd_idx_reg    <= rd_idx_next;
        rd_oor_reg    <= rd_oor_next;
        pend_sym_reg  <= pend_sym_next;
        out_sym_reg   <= out_sym_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign symbol    = out_sym_reg;
    assign last      = out_last_reg;

endmodule

// ===== hw/rtl/htwd_checker.sv =====
`include "huffman_tree_walk_decoder_core_defines.svh"

module htwd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] cmd,
    input logic [3:0] valid_bits,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] symbol,
    input logic       last
);
    import htwd_pkg::*;

    // A stalled result holds
    `HTWD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(symbol) && $stable(last), "result changed while stalled")

    // A decode with bits to walk closes the input for the next cycle
    `HTWD_ASSERT_NEXT(a_decode_busy, clk, rst_n, in_valid && in_ready && cmd == CMD_DECODE && valid_bits != 4'd0, !in_ready, "input open during a walk")

    // Node writes and restarts leave the input open in the next cycle
    `HTWD_ASSERT_NEXT(a_write_quick, clk, rst_n, in_valid && in_ready && (cmd == CMD_WRITE || cmd == CMD_RESTART), in_ready, "input closed after a one-cycle command")

    // Results appear only out of a walk
    `HTWD_ASSERT_SAME(a_out_from_walk, clk, rst_n, $rose(out_valid), $past(!in_ready), "result without a walk")

endmodule

bind huffman_tree_walk_decoder_core htwd_checker u_htwd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .valid_bits (valid_bits),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .symbol     (symbol),
    .last       (last)
);
